// File: rtl/mfmt_pkg.sv
`default_nettype none
package mfmt_pkg;

  localparam int SlotCountDef     = 4;
  localparam int CountsPerTurnDef = 8192;
  localparam int RegSlots         = 4;
  localparam int IdW              = 11;
  localparam int MotorIdW         = 8;
  localparam int EncW             = 16;
  localparam int AgeW             = 16;
  localparam int TurnW            = 32;
  localparam int PosW             = 45;
  localparam int CfgIdxW          = 3;
  localparam int CfgDataW         = 16;

  localparam logic [IdW-1:0]      IdBase = 11'h200;
  localparam logic [AgeW-1:0]     AgeMax = 16'hFFFF;
  localparam logic [MotorIdW-1:0] SlotIdReset [RegSlots] = '{8'd4, 8'd1, 8'd3, 8'd2};

  typedef enum logic [CfgIdxW-1:0] {
    RegSlot0Id  = 3'd0,
    RegSlot1Id  = 3'd1,
    RegSlot2Id  = 3'd2,
    RegSlot3Id  = 3'd3,
    RegIdLowest = 3'd4,
    RegIdHigh   = 3'd5,
    RegTimeout  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [IdW-1:0]  id_lo;
    logic [IdW-1:0]  id_hi;
    logic [AgeW-1:0] timeout;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/motor_feedback_multiturn_tracker_unit.sv
// Pipeline: 3 register stages; an accepted word passes stage 1, stage 2 and the output registers in order.
// Throughput: one word per cycle unless out_ready_i stalls; the turn-count memory is read and
// written at most once per cycle, the last write forwarded to a same-slot read at the same edge.
// Reset: control registers take their documented defaults, ages saturate, no slot is seen.
// Memory contents are undefined after reset; the per-slot seen flags mask them, no clearing pass.
`default_nettype none
module motor_feedback_multiturn_tracker_unit #(
  parameter int SLOT_COUNT      = mfmt_pkg::SlotCountDef,
  parameter int COUNTS_PER_TURN = mfmt_pkg::CountsPerTurnDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mfmt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mfmt_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [mfmt_pkg::IdW-1:0]      frame_id_i,
  input  wire logic [63:0]                   payload_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               accepted_o,
  output logic [1:0]                         slot_o,
  output logic [15:0]                        encoder_o,
  output logic signed [15:0]                 speed_o,
  output logic signed [15:0]                 current_reading_o,
  output logic [7:0]                         temperature_o,
  output logic signed [31:0]                 turns_o,
  output logic signed [44:0]                 total_position_o,
  output logic [3:0]                         online_slots_o
);

  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int EncW  = mfmt_pkg::EncW;
  localparam int TurnW = mfmt_pkg::TurnW;
  localparam int AgeW  = mfmt_pkg::AgeW;
  localparam int PosW  = mfmt_pkg::PosW;
  localparam int EntW  = EncW + TurnW;
  localparam int CptW  = 17;
  localparam int Half  = COUNTS_PER_TURN / 2;
  localparam logic [CptW-1:0]    CptVal  = CptW'(COUNTS_PER_TURN);
  localparam logic signed [17:0] HalfPos = 18'(Half);
  localparam logic signed [17:0] HalfNeg = -HalfPos;

  // match / config
  logic             m_hit;
  logic [SlotW-1:0] m_slot;
  logic [AgeW-1:0]  timeout;

  mfmt_cfg #(
    .SLOT_COUNT (SLOT_COUNT),
    .SlotW      (SlotW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_i),
    .frame_id_i (frame_id_i),
    .hit_o      (m_hit),
    .slot_o     (m_slot),
    .timeout_o  (timeout)
  );

  // pipeline control
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_load, s2_load, s3_load, s1_fire;

  assign s3_load    = !s3_v_q || out_ready_i;
  assign s2_load    = !s2_v_q || s3_load;
  assign s1_load    = !s1_v_q || s2_load;
  assign s1_fire    = s1_v_q && s2_load;
  assign in_ready_o = s1_load;

  // slot memory: {last encoder, turn count}
  logic [EntW-1:0] mem [SLOT_COUNT];
  logic [EntW-1:0] rd_q;

  // stage 1
  logic             s1_hit_q, s1_tick_q;
  logic [SlotW-1:0] s1_slot_q;
  logic [63:0]      s1_pl_q;

  // last write, forwarded to a read issued at the same edge
  logic             lw_v_q;
  logic [SlotW-1:0] lw_slot_q;
  logic [EntW-1:0]  lw_data_q;

  logic [SLOT_COUNT-1:0] seen_q, seen_n;
  logic [AgeW-1:0]       age_q [SLOT_COUNT];
  logic [AgeW-1:0]       age_n [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] online;

  logic [EntW-1:0]         old_ent;
  logic [EncW-1:0]         s1_enc;
  logic [EncW-1:0]         old_enc;
  logic [TurnW-1:0]        old_turns, new_turns;
  logic signed [17:0]      diff;
  logic [SlotW+1:0]        slot_ext;
  logic [SLOT_COUNT+3:0]   mask_ext;

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      rd_q      <= mem[m_slot];
      s1_slot_q <= m_slot;
      s1_pl_q   <= payload_i;
    end
    if (s1_fire && s1_hit_q) begin
      mem[s1_slot_q] <= {s1_enc, new_turns};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_hit_q  <= 1'b0;
      s1_tick_q <= 1'b0;
      lw_v_q    <= 1'b0;
      lw_slot_q <= '0;
      lw_data_q <= '0;
      seen_q    <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) age_q[i] <= mfmt_pkg::AgeMax;
    end else begin
      if (s1_load) begin
        s1_v_q    <= in_valid_i;
        s1_hit_q  <= in_valid_i && m_hit;
        s1_tick_q <= in_valid_i && cmd_i;
      end
      if (s1_fire) begin
        seen_q <= seen_n;
        for (int i = 0; i < SLOT_COUNT; i++) age_q[i] <= age_n[i];
        if (s1_hit_q) begin
          lw_v_q    <= 1'b1;
          lw_slot_q <= s1_slot_q;
          lw_data_q <= {s1_enc, new_turns};
        end
      end
    end
  end

  assign s1_enc = s1_pl_q[63:48];

  always_comb begin
    if (!seen_q[s1_slot_q]) begin
      old_ent = '0;
    end else if (lw_v_q && lw_slot_q == s1_slot_q) begin
      old_ent = lw_data_q;
    end else begin
      old_ent = rd_q;
    end
    old_enc   = old_ent[EntW-1:TurnW];
    old_turns = old_ent[TurnW-1:0];
    diff      = $signed({2'b00, s1_enc}) - $signed({2'b00, old_enc});
    new_turns = old_turns;
    if (seen_q[s1_slot_q]) begin
      if (diff > HalfPos) begin
        new_turns = old_turns - 32'd1;
      end else if (diff < HalfNeg) begin
        new_turns = old_turns + 32'd1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      seen_n[i] = seen_q[i];
      age_n[i]  = age_q[i];
      if (s1_tick_q && age_q[i] != mfmt_pkg::AgeMax) begin
        age_n[i] = age_q[i] + AgeW'(1);
      end
      if (s1_hit_q && s1_slot_q == SlotW'(i)) begin
        seen_n[i] = 1'b1;
        age_n[i]  = '0;
      end
      online[i] = seen_n[i] && age_n[i] <= timeout;
    end
  end

  assign slot_ext = {2'b00, s1_slot_q};
  assign mask_ext = {4'b0000, online};

  // stage 2
  logic                    s2_acc_q;
  logic [1:0]              s2_slot_q;
  logic [63:0]             s2_pl_q;
  logic signed [TurnW-1:0] s2_turns_q;
  logic [3:0]              s2_mask_q;
  logic signed [TurnW+CptW:0] prod;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      s2_acc_q   <= s1_hit_q;
      s2_slot_q  <= s1_hit_q ? slot_ext[1:0] : 2'b00;
      s2_pl_q    <= s1_hit_q ? s1_pl_q : 64'd0;
      s2_turns_q <= s1_hit_q ? new_turns : '0;
      s2_mask_q  <= mask_ext[3:0];
    end
  end

  assign prod = s2_turns_q * $signed({1'b0, CptVal});

  // stage 3 / output
  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      accepted_o        <= s2_acc_q;
      slot_o            <= s2_slot_q;
      encoder_o         <= s2_pl_q[63:48];
      speed_o           <= s2_pl_q[47:32];
      current_reading_o <= s2_pl_q[31:16];
      temperature_o     <= s2_pl_q[15:8];
      turns_o           <= s2_turns_q;
      total_position_o  <= prod[PosW-1:0] + {{(PosW-EncW){1'b0}}, s2_pl_q[63:48]};
      online_slots_o    <= s2_mask_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s2_load) s2_v_q <= s1_v_q;
      if (s3_load) s3_v_q <= s2_v_q;
    end
  end

  assign out_valid_o = s3_v_q;

  // seen flags only ever set
  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q & $past(seen_q)) == $past(seen_q))
    else $error("seen flag cleared");

  // a taken frame leaves its slot online
  a_taken_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o && SLOT_COUNT <= 4 |-> online_slots_o[slot_o])
    else $error("taken slot not online");

  // rejected frames and ticks carry no position
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> turns_o == 0 && total_position_o == 0 && slot_o == 0)
    else $error("nonzero fields on rejected word");

  // forwarded entry is only ever for a slot already seen
  a_fwd_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lw_v_q |-> seen_q[lw_slot_q])
    else $error("forward entry for unseen slot");

endmodule
`default_nettype wire

// File: rtl/mfmt_cfg.sv
`default_nettype none
module mfmt_cfg #(
  parameter int SLOT_COUNT = mfmt_pkg::SlotCountDef,
  parameter int SlotW      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mfmt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mfmt_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          cmd_i,
  input  wire logic [mfmt_pkg::IdW-1:0]      frame_id_i,
  output logic                               hit_o,
  output logic [SlotW-1:0]                   slot_o,
  output logic [mfmt_pkg::AgeW-1:0]          timeout_o
);

  mfmt_pkg::cfg_t                  cfg_q;
  logic [mfmt_pkg::MotorIdW-1:0]   ids [SLOT_COUNT];
  logic [mfmt_pkg::MotorIdW-1:0]   mid;
  logic                            in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.id_lo   <= 11'd513;
      cfg_q.id_hi   <= 11'd516;
      cfg_q.timeout <= 16'd100;
    end else if (cfg_we_i) begin
      case (mfmt_pkg::reg_idx_e'(cfg_idx_i))
        mfmt_pkg::RegIdLowest: cfg_q.id_lo   <= cfg_data_i[mfmt_pkg::IdW-1:0];
        mfmt_pkg::RegIdHigh:   cfg_q.id_hi   <= cfg_data_i[mfmt_pkg::IdW-1:0];
        mfmt_pkg::RegTimeout:  cfg_q.timeout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_id
    if (i < mfmt_pkg::RegSlots) begin : g_reg
      logic [mfmt_pkg::MotorIdW-1:0] id_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          id_q <= mfmt_pkg::SlotIdReset[i];
        end else if (cfg_we_i && cfg_idx_i == mfmt_pkg::CfgIdxW'(i)) begin
          id_q <= cfg_data_i[mfmt_pkg::MotorIdW-1:0];
        end
      end
      assign ids[i] = id_q;
    end else begin : g_zero
      assign ids[i] = '0;
    end
  end

  assign mid       = mfmt_pkg::MotorIdW'(frame_id_i - mfmt_pkg::IdBase);
  assign in_range  = !cmd_i && frame_id_i >= cfg_q.id_lo && frame_id_i <= cfg_q.id_hi;
  assign timeout_o = cfg_q.timeout;

  // lowest slot wins
  always_comb begin
    hit_o  = 1'b0;
    slot_o = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (in_range && ids[i] == mid) begin
        hit_o  = 1'b1;
        slot_o = SlotW'(i);
      end
    end
  end

endmodule
`default_nettype wire
